/* design/lzsd_pkg.sv */
// Shared types and constants for the LZ sprite decompressor.
`timescale 1ns / 1ps
package lzsd_pkg;

  localparam int unsigned CountW = 27;
  localparam int unsigned OffsetW = 11;
  localparam int unsigned LenW = 5;

  localparam logic [CountW-1:0] MAX_SIZE = 27'h400_0000;
  localparam logic [7:0] HDR_REF_BIT = 8'h80;
  localparam logic [LenW-1:0] MAX_COPY_LEN = 5'd16;
  localparam logic [7:0] LIT_RUN_ZERO_LEN = 8'd128;

  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_OVERRUN = 2'd1;
  localparam logic [1:0] ST_OFFSET = 2'd2;

  typedef enum logic [1:0] {
    PH_DONE,
    PH_HEADER,
    PH_LITERAL,
    PH_OFFSET
  } phase_e;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_COPY,
    CMD_FAIL
  } cmd_kind_e;

  typedef enum logic [1:0] {
    SRC_LIT,
    SRC_ZERO,
    SRC_MEM
  } src_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic               restart;
    logic [7:0]         lit;
    logic [OffsetW-1:0] offset;
    logic [LenW-1:0]    len;
    logic [1:0]         status;
    logic               last;
  } cmd_t;

endpackage

/* design/lzsd_front.sv */
// Token parser: classifies compressed bytes and issues copy/literal/error commands.
`timescale 1ns / 1ps
module lzsd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      in_start_i,
  input  logic [7:0]                in_byte_i,
  input  logic [lzsd_pkg::CountW-1:0] size_i,
  input  logic                      cmd_full_i,
  output logic                      cmd_push_o,
  output lzsd_pkg::cmd_t            cmd_o
);
  import lzsd_pkg::*;

  phase_e              phase_q, phase_d, eph;
  logic [CountW-1:0]   prod_q, prod_d, prod_e;
  logic [7:0]          lit_left_q, lit_left_d, lit_e, lit_dec;
  logic [2:0]          off_hi_q, off_hi_d, off_hi_e;
  logic [LenW-1:0]     copy_len_q, copy_len_d, len_e, len_eff;
  logic                restart_q, restart_d;
  logic                accept, failed;
  logic [7:0]          run_len;
  logic [CountW:0]     sum_lit, sum_copy;
  logic [OffsetW-1:0]  off;
  logic [CountW-1:0]   prod_inc;

  assign in_ready_o = !cmd_full_i;
  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_DONE;
      prod_q     <= '0;
      lit_left_q <= '0;
      off_hi_q   <= '0;
      copy_len_q <= '0;
      restart_q  <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      prod_q     <= prod_d;
      lit_left_q <= lit_left_d;
      off_hi_q   <= off_hi_d;
      copy_len_q <= copy_len_d;
      restart_q  <= restart_d;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    prod_d     = prod_q;
    lit_left_d = lit_left_q;
    off_hi_d   = off_hi_q;
    copy_len_d = copy_len_q;
    restart_d  = restart_q;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    cmd_o.kind = CMD_FAIL;
    failed     = 1'b0;
    eph        = phase_q;
    prod_e     = prod_q;
    lit_e      = lit_left_q;
    off_hi_e   = off_hi_q;
    len_e      = copy_len_q;
    run_len    = (in_byte_i == 8'd0) ? LIT_RUN_ZERO_LEN : in_byte_i;
    off        = {off_hi_q, in_byte_i};
    lit_dec    = '0;
    len_eff    = MAX_COPY_LEN;
    sum_lit    = '0;
    sum_copy   = '0;
    prod_inc   = '0;

    if (accept) begin
      cmd_o.restart = restart_q || in_start_i;
      if (in_start_i) begin
        prod_e   = '0;
        lit_e    = '0;
        off_hi_e = '0;
        len_e    = '0;
        if (size_i > MAX_SIZE) begin
          failed       = 1'b1;
          cmd_push_o   = 1'b1;
          cmd_o.kind   = CMD_FAIL;
          cmd_o.status = ST_OVERRUN;
          cmd_o.last   = 1'b1;
          eph          = PH_DONE;
        end else begin
          eph = (size_i == '0) ? PH_DONE : PH_HEADER;
        end
      end
      prod_d     = prod_e;
      lit_left_d = lit_e;
      off_hi_d   = off_hi_e;
      copy_len_d = len_e;
      phase_d    = eph;

      if (!failed) begin
        unique case (eph)
          PH_HEADER: begin
            if ((in_byte_i & HDR_REF_BIT) == 8'd0) begin
              sum_lit = {1'b0, prod_e} + (CountW+1)'(run_len);
              if (sum_lit > {1'b0, size_i}) begin
                cmd_push_o   = 1'b1;
                cmd_o.kind   = CMD_FAIL;
                cmd_o.status = ST_OVERRUN;
                cmd_o.last   = 1'b1;
                phase_d      = PH_DONE;
              end else begin
                lit_left_d = run_len;
                phase_d    = PH_LITERAL;
              end
            end else begin
              off_hi_d   = in_byte_i[2:0];
              copy_len_d = MAX_COPY_LEN - {1'b0, in_byte_i[6:3]};
              phase_d    = PH_OFFSET;
            end
          end
          PH_LITERAL: begin
            prod_inc     = prod_e + 1'b1;
            lit_dec      = lit_e - 1'b1;
            prod_d       = prod_inc;
            lit_left_d   = lit_dec;
            cmd_push_o   = 1'b1;
            cmd_o.kind   = CMD_LIT;
            cmd_o.lit    = in_byte_i;
            cmd_o.status = ST_DATA;
            cmd_o.last   = (prod_inc == size_i);
            if (prod_inc == size_i) begin
              phase_d = PH_DONE;
            end else if (lit_dec == 8'd0) begin
              phase_d = PH_HEADER;
            end
          end
          PH_OFFSET: begin
            len_eff  = (len_e == '0 || len_e > MAX_COPY_LEN) ? MAX_COPY_LEN : len_e;
            sum_copy = {1'b0, prod_e} + (CountW+1)'(len_eff);
            cmd_push_o = 1'b1;
            cmd_o.last = 1'b1;
            if ((CountW)'(off) > prod_e) begin
              cmd_o.kind   = CMD_FAIL;
              cmd_o.status = ST_OFFSET;
              phase_d      = PH_DONE;
            end else if (sum_copy > {1'b0, size_i}) begin
              cmd_o.kind   = CMD_FAIL;
              cmd_o.status = ST_OVERRUN;
              phase_d      = PH_DONE;
            end else begin
              cmd_o.kind   = CMD_COPY;
              cmd_o.offset = off;
              cmd_o.len    = len_eff;
              cmd_o.status = ST_DATA;
              cmd_o.last   = (sum_copy[CountW-1:0] == size_i);
              prod_d       = sum_copy[CountW-1:0];
              off_hi_d     = '0;
              copy_len_d   = '0;
              phase_d      = (sum_copy[CountW-1:0] == size_i) ? PH_DONE : PH_HEADER;
            end
          end
          default: begin
            phase_d = eph;
          end
        endcase
      end
      restart_d = cmd_push_o ? 1'b0 : (restart_q || in_start_i);
    end
  end

endmodule

/* design/lzsd_cmd_fifo.sv */
// Small command queue between the parser and the copy engine.
`timescale 1ns / 1ps
module lzsd_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lzsd_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output lzsd_pkg::cmd_t data_o
);
  import lzsd_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW = $clog2(Depth);

  cmd_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o  = (count_q == (PtrW+1)'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* design/lzsd_back.sv */
// Copy engine: history memory, byte sequencer and output register.
`timescale 1ns / 1ps
module lzsd_back #(
  parameter int unsigned HISTORY_DEPTH = 2048
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  lzsd_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic [1:0]     out_status_o,
  output logic           out_end_o,
  output logic           out_last_o
);
  import lzsd_pkg::*;

  localparam int unsigned AddrW = $clog2(HISTORY_DEPTH);
  localparam logic [AddrW:0] DepthExt = (AddrW+1)'(HISTORY_DEPTH);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(HISTORY_DEPTH - 1);

  function automatic logic [AddrW-1:0] ptr_inc(input logic [AddrW-1:0] p);
    ptr_inc = (p == LastAddr) ? '0 : p + 1'b1;
  endfunction

  logic [7:0]       hist_mem [HISTORY_DEPTH];
  logic [7:0]       rd_data_q, last_wr_q, s1_value;
  logic             adv, mem_we;

  // sequencer
  logic             busy_q, busy_d, zero_q, zero_d, cp_end_q, cp_end_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] src_q, src_d, wptr_q, wptr_d, base;
  logic [AddrW:0]   src_ext;

  // issue to stage 1
  logic             iss_valid, iss_data, iss_last, iss_re;
  src_e             iss_src;
  logic [7:0]       iss_lit;
  logic [AddrW-1:0] iss_waddr, rd_addr;
  logic [1:0]       iss_status;

  // stage 1: read data in flight
  logic             s1_valid_q, s1_data_q, s1_fwd_q, s1_last_q, s1_end_q;
  src_e             s1_src_q;
  logic [7:0]       s1_lit_q;
  logic [AddrW-1:0] s1_waddr_q;
  logic [1:0]       s1_status_q;
  logic             iss_end;

  assign adv    = !out_valid_o || out_ready_i;
  assign mem_we = adv && s1_valid_q && s1_data_q;

  always_comb begin
    unique case (s1_src_q)
      SRC_LIT:  s1_value = s1_lit_q;
      SRC_MEM:  s1_value = s1_fwd_q ? last_wr_q : rd_data_q;
      default:  s1_value = 8'd0;
    endcase
  end

  always_comb begin
    busy_d     = busy_q;
    cnt_d      = cnt_q;
    src_d      = src_q;
    wptr_d     = wptr_q;
    zero_d     = zero_q;
    cp_end_d   = cp_end_q;
    cmd_pop_o  = 1'b0;
    iss_valid  = 1'b0;
    iss_data   = 1'b0;
    iss_src    = SRC_ZERO;
    iss_lit    = cmd_i.lit;
    iss_waddr  = wptr_q;
    iss_status = ST_DATA;
    iss_last   = 1'b0;
    iss_end    = 1'b0;
    iss_re     = 1'b0;
    rd_addr    = src_q;
    base       = cmd_i.restart ? '0 : wptr_q;
    src_ext    = {1'b0, base} - (AddrW+1)'(cmd_i.offset);
    if (src_ext[AddrW]) begin
      src_ext = src_ext + DepthExt;
    end

    if (adv) begin
      if (busy_q) begin
        iss_valid = 1'b1;
        iss_data  = 1'b1;
        iss_src   = zero_q ? SRC_ZERO : SRC_MEM;
        iss_re    = !zero_q;
        iss_last  = (cnt_q == LenW'(1));
        iss_end   = iss_last && cp_end_q;
        cnt_d     = cnt_q - 1'b1;
        busy_d    = !iss_last;
        src_d     = ptr_inc(src_q);
        wptr_d    = ptr_inc(wptr_q);
      end else if (!cmd_empty_i) begin
        cmd_pop_o = 1'b1;
        iss_valid = 1'b1;
        iss_waddr = base;
        iss_last  = 1'b1;
        wptr_d    = base;
        unique case (cmd_i.kind)
          CMD_LIT: begin
            iss_data = 1'b1;
            iss_src  = SRC_LIT;
            iss_end  = cmd_i.last;
            wptr_d   = ptr_inc(base);
          end
          CMD_COPY: begin
            iss_data = 1'b1;
            zero_d   = (cmd_i.offset == '0);
            iss_src  = zero_d ? SRC_ZERO : SRC_MEM;
            iss_re   = !zero_d;
            rd_addr  = src_ext[AddrW-1:0];
            src_d    = ptr_inc(src_ext[AddrW-1:0]);
            wptr_d   = ptr_inc(base);
            cnt_d    = cmd_i.len - 1'b1;
            iss_last = (cmd_i.len == LenW'(1));
            busy_d   = !iss_last;
            cp_end_d = cmd_i.last;
            iss_end  = iss_last && cmd_i.last;
          end
          default: begin
            iss_status = cmd_i.status;
            iss_end    = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[s1_waddr_q] <= s1_value;
    end
    if (adv && iss_re) begin
      rd_data_q <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      last_wr_q <= s1_value;
    end
    if (adv) begin
      s1_data_q   <= iss_data;
      s1_src_q    <= iss_src;
      s1_lit_q    <= iss_lit;
      s1_waddr_q  <= iss_waddr;
      s1_status_q <= iss_status;
      s1_last_q   <= iss_last;
      s1_end_q    <= iss_end;
      // read and write of the same entry on one edge: take the written byte
      s1_fwd_q    <= s1_valid_q && s1_data_q && (s1_waddr_q == rd_addr);
    end
    if (adv && s1_valid_q) begin
      out_byte_o   <= s1_value;
      out_status_o <= s1_status_q;
      out_end_o    <= s1_end_q;
      out_last_o   <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      src_q       <= '0;
      wptr_q      <= '0;
      zero_q      <= 1'b0;
      cp_end_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      cnt_q    <= cnt_d;
      src_q    <= src_d;
      wptr_q   <= wptr_d;
      zero_q   <= zero_d;
      cp_end_q <= cp_end_d;
      if (adv) begin
        s1_valid_q  <= iss_valid;
        out_valid_o <= s1_valid_q;
      end
    end
  end

endmodule

/* design/lz_sprite_decompressor.sv */
// Top level of the LZ sprite decompressor: size register, parser, queue, copy engine.
// Each command goes from the queue through the stage-1 register to the output register.
// Throughput: one output byte per cycle while commands are queued and the output is not
// stalled; a literal gives one byte, a back-reference 1 to 16 bytes via the single history read port.
// The parser takes one byte per cycle while the 4-entry command queue has room.
// Reset (rst_ni low, asynchronous) empties the queue, stops the engine and ends
// the sprite; history contents are left as they are.
`timescale 1ns / 1ps
module lz_sprite_decompressor #(
  parameter int unsigned HISTORY_DEPTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [26:0] cfg_wdata_i,     // output_size
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] compressed_byte
  input  logic        s_axis_tuser_i,  // [0] start_of_sprite
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] out_byte
  output logic [2:0]  m_axis_tuser_o,  // [1:0] status, [2] last_of_run
  output logic        m_axis_tlast_o   // end_of_sprite
);
  import lzsd_pkg::*;

  logic [CountW-1:0] size_q;
  logic              cmd_push, cmd_pop, cmd_full, cmd_empty;
  cmd_t              cmd_in, cmd_out;
  logic [1:0]        out_status;
  logic              out_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  lzsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_start_i (s_axis_tuser_i),
    .in_byte_i  (s_axis_tdata_i),
    .size_i     (size_q),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  lzsd_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_out)
  );

  lzsd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_empty_i  (cmd_empty),
    .cmd_i        (cmd_out),
    .cmd_pop_o    (cmd_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (m_axis_tdata_o),
    .out_status_o (out_status),
    .out_end_o    (m_axis_tlast_o),
    .out_last_o   (out_last)
  );

  assign m_axis_tuser_o = {out_last, out_status};

endmodule

/* design/lzsd_checker.sv */
// Port-level assertions for the LZ sprite decompressor, bound to the top level.
`timescale 1ns / 1ps
module lzsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import lzsd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("output transfer dropped or changed while stalled");

  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1:0] != ST_DATA |->
      m_axis_tdata_o == 8'd0 && m_axis_tlast_o && m_axis_tuser_o[2]
      && (m_axis_tuser_o[1:0] == ST_OVERRUN || m_axis_tuser_o[1:0] == ST_OFFSET))
    else $error("malformed error result");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o[2])
    else $error("end of sprite inside a run");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid during reset");

endmodule

bind lz_sprite_decompressor lzsd_checker u_lzsd_checker (.*);
